// ===== design/fss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fss_pkg
// Shared codes for the thread scheduler: actions, status codes and the
// operation select of the shared time unit.
// ----------------------------------------------------------------------------
package fss_pkg;

    localparam int ACTION_W = 3;
    localparam int ID_W     = 4;
    localparam int PORT_T_W = 64;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CREATE      = 3'd0,
        ACT_YIELD       = 3'd1,
        ACT_SLEEP_UNTIL = 3'd2,
        ACT_SLEEP_FOR   = 3'd3,
        ACT_TICK        = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_IDLE_SLEEP = 2'd2
    } t_status;

    // saturating add of two times, or a <= b compare via b - a
    typedef enum logic {
        ALU_SAT_ADD = 1'b0,
        ALU_LE      = 1'b1
    } t_alu_op;

endpackage

`default_nettype wire

// ===== design/fss_time_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fss_time_alu
// One shared time adder: saturating now + duration, or the wake time
// compare (a <= b) taken from the carry of b - a.
// ----------------------------------------------------------------------------
module fss_time_alu
    import fss_pkg::*;
#(
    parameter int TIME_BITS = 64
) (
    input  wire t_alu_op              i_op,
    input  wire logic [TIME_BITS-1:0] i_a,
    input  wire logic [TIME_BITS-1:0] i_b,
    output logic      [TIME_BITS-1:0] o_result,
    output logic                      o_flag
);

    logic [TIME_BITS-1:0] opnd_x;
    logic [TIME_BITS-1:0] opnd_y;
    logic [TIME_BITS:0]   sum;

    always_comb begin
        if (i_op == ALU_LE) begin
            opnd_x = i_b;
            opnd_y = ~i_a;
        end else begin
            opnd_x = i_a;
            opnd_y = i_b;
        end
        sum = {1'b0, opnd_x} + {1'b0, opnd_y} + {{TIME_BITS{1'b0}}, (i_op == ALU_LE)};
    end

    // carry out: overflow on add, no borrow (a <= b) on compare
    assign o_flag   = sum[TIME_BITS];
    assign o_result = (i_op == ALU_SAT_ADD && sum[TIME_BITS]) ? {TIME_BITS{1'b1}}
                                                              : sum[TIME_BITS-1:0];

endmodule

`default_nettype wire

// ===== design/fifo_scheduler_with_timed_sleep.sv =====
// Order, accept to result valid: dispatch then done; yield adds the yield state
// when a thread is ready. A rejected sleep ends at dispatch; a sleep compares
// sleepers from the tail on the shared time unit, writes its slot, then yields
// when a ready thread takes over; tick compares sleepers from the head. Input
// stall drops with result valid; output stall delays both. Reset is synchronous:
// queues empty, boot thread 0 running; memories are kept and need no clearing.
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_scheduler_with_timed_sleep
// Thread scheduler: FIFO ready queue, wake-time sorted sleep queue kept as a
// circular buffer, and a small sequencer around one shared time unit.
// ----------------------------------------------------------------------------
module fifo_scheduler_with_timed_sleep
    import fss_pkg::*;
#(
    parameter int MAX_THREADS = 16,
    parameter int TIME_BITS   = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [ACTION_W-1:0] i_action,
    input  wire logic [ID_W-1:0]     i_thread_id,
    input  wire logic [PORT_T_W-1:0] i_time_value,
    input  wire logic [PORT_T_W-1:0] i_now,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [ID_W-1:0]          o_running_thread,
    output logic                     o_running_is_idle,
    output logic [COUNT_W-1:0]       o_woken_count,
    output logic [COUNT_W-1:0]       o_ready_count,
    output logic [COUNT_W-1:0]       o_sleeping_count,
    output logic [STATUS_W-1:0]      o_status
);

    localparam int IW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam int SW = CW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CMP,
        S_INS_WR,
        S_YIELD,
        S_TK_CMP,
        S_DONE
    } t_state;

    // (a + b) mod MAX_THREADS, a below MAX_THREADS, b at most MAX_THREADS
    function automatic logic [IW-1:0] f_wrap(input logic [IW-1:0] a, input logic [CW-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (s >= SW'(MAX_THREADS)) begin
            s = s - SW'(MAX_THREADS);
        end
        return s[IW-1:0];
    endfunction

    // memories
    logic [ID_W-1:0]      rq_mem   [MAX_THREADS];
    logic [ID_W-1:0]      sq_id    [MAX_THREADS];
    logic [TIME_BITS-1:0] sq_time  [MAX_THREADS];
    logic [ID_W-1:0]      r_rq_rd;
    logic [ID_W-1:0]      r_sq_rd_id;
    logic [TIME_BITS-1:0] r_sq_rd_time;

    logic                 rq_we;
    logic [IW-1:0]        rq_waddr;
    logic [ID_W-1:0]      rq_wdata;
    logic                 sq_we;
    logic [IW-1:0]        sq_waddr;
    logic [ID_W-1:0]      sq_wid;
    logic [TIME_BITS-1:0] sq_wtime;
    logic [IW-1:0]        sq_raddr;

    // control and datapath registers
    t_state               r_state, n_state;
    logic [ACTION_W-1:0]  r_action, n_action;
    logic [ID_W-1:0]      r_tid, n_tid;
    logic [TIME_BITS-1:0] r_tv, n_tv;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [TIME_BITS-1:0] r_key, n_key;
    logic [CW-1:0]        r_k, n_k;
    logic [IW-1:0]        r_ready_head, n_ready_head;
    logic [CW-1:0]        r_ready_fill, n_ready_fill;
    logic [IW-1:0]        r_sleep_head, n_sleep_head;
    logic [CW-1:0]        r_sleep_fill, n_sleep_fill;
    logic [ID_W-1:0]      r_cur_id, n_cur_id;
    logic                 r_cur_idle, n_cur_idle;
    logic                 r_cur_sleeping, n_cur_sleeping;
    logic [CW-1:0]        r_woken, n_woken;
    t_status              r_status, n_status;

    logic                 r_out_valid, n_out_valid;
    logic [ID_W-1:0]      r_out_thread, n_out_thread;
    logic                 r_out_idle, n_out_idle;
    logic [COUNT_W-1:0]   r_out_woken, n_out_woken;
    logic [COUNT_W-1:0]   r_out_ready, n_out_ready;
    logic [COUNT_W-1:0]   r_out_sleeping, n_out_sleeping;
    t_status              r_out_status, n_out_status;

    // shared time unit
    t_alu_op              alu_op;
    logic [TIME_BITS-1:0] alu_a;
    logic [TIME_BITS-1:0] alu_b;
    logic [TIME_BITS-1:0] alu_result;
    logic                 alu_flag;

    fss_time_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_result (alu_result),
        .o_flag   (alu_flag)
    );

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state        = r_state;
        n_action       = r_action;
        n_tid          = r_tid;
        n_tv           = r_tv;
        n_now          = r_now;
        n_key          = r_key;
        n_k            = r_k;
        n_ready_head   = r_ready_head;
        n_ready_fill   = r_ready_fill;
        n_sleep_head   = r_sleep_head;
        n_sleep_fill   = r_sleep_fill;
        n_cur_id       = r_cur_id;
        n_cur_idle     = r_cur_idle;
        n_cur_sleeping = r_cur_sleeping;
        n_woken        = r_woken;
        n_status       = r_status;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_thread   = r_out_thread;
        n_out_idle     = r_out_idle;
        n_out_woken    = r_out_woken;
        n_out_ready    = r_out_ready;
        n_out_sleeping = r_out_sleeping;
        n_out_status   = r_out_status;

        rq_we    = 1'b0;
        rq_waddr = f_wrap(r_ready_head, r_ready_fill);
        rq_wdata = r_cur_id;
        sq_we    = 1'b0;
        sq_waddr = f_wrap(r_sleep_head, r_k);
        sq_wid   = r_sq_rd_id;
        sq_wtime = r_sq_rd_time;
        sq_raddr = r_sleep_head;

        alu_op = ALU_LE;
        alu_a  = r_sq_rd_time;
        alu_b  = r_key;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action = i_action;
                    n_tid    = i_thread_id;
                    n_tv     = i_time_value[TIME_BITS-1:0];
                    n_now    = i_now[TIME_BITS-1:0];
                    n_status = ST_OK;
                    n_woken  = '0;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_DONE;
                alu_op  = ALU_SAT_ADD;
                alu_a   = r_now;
                alu_b   = r_tv;
                unique case (r_action) inside
                    ACT_CREATE: begin
                        if (r_ready_fill == CW'(MAX_THREADS)) begin
                            n_status = ST_FULL;
                        end else begin
                            rq_we        = 1'b1;
                            rq_wdata     = r_tid;
                            n_ready_fill = r_ready_fill + CW'(1);
                        end
                    end
                    ACT_YIELD: begin
                        if (r_ready_fill == '0) begin
                            if (r_cur_sleeping) begin
                                n_cur_idle     = 1'b1;
                                n_cur_sleeping = 1'b0;
                                n_cur_id       = '0;
                            end
                        end else begin
                            n_state = S_YIELD;
                        end
                    end
                    ACT_SLEEP_UNTIL, ACT_SLEEP_FOR: begin
                        n_key = (r_action == ACT_SLEEP_FOR) ? alu_result : r_tv;
                        if (r_cur_idle) begin
                            n_status = ST_IDLE_SLEEP;
                        end else if (r_sleep_fill == CW'(MAX_THREADS)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_k = r_sleep_fill;
                            if (r_sleep_fill == '0) begin
                                n_state = S_INS_WR;
                            end else begin
                                sq_raddr = f_wrap(r_sleep_head, r_sleep_fill - CW'(1));
                                n_state  = S_INS_CMP;
                            end
                        end
                    end
                    ACT_TICK: begin
                        n_key = r_now;
                        if (r_sleep_fill != '0) begin
                            n_state = S_TK_CMP;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_INS_CMP: begin
                // walk back from the tail, moving later wake times up a slot
                if (!alu_flag) begin
                    sq_we = 1'b1;
                    n_k   = r_k - CW'(1);
                    if (r_k == CW'(1)) begin
                        n_state = S_INS_WR;
                    end else begin
                        sq_raddr = f_wrap(r_sleep_head, r_k - CW'(2));
                    end
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                sq_we        = 1'b1;
                sq_wid       = r_cur_id;
                sq_wtime     = r_key;
                n_sleep_fill = r_sleep_fill + CW'(1);
                if (r_ready_fill == '0) begin
                    n_cur_idle     = 1'b1;
                    n_cur_sleeping = 1'b0;
                    n_cur_id       = '0;
                    n_state        = S_DONE;
                end else begin
                    n_cur_sleeping = 1'b1;
                    n_state        = S_YIELD;
                end
            end
            S_YIELD: begin
                // head already popped by index; tail slot is unchanged by the pop
                n_cur_id     = r_rq_rd;
                n_ready_head = f_wrap(r_ready_head, CW'(1));
                if (!r_cur_sleeping && !r_cur_idle) begin
                    rq_we = 1'b1;
                end else begin
                    n_ready_fill = r_ready_fill - CW'(1);
                end
                n_cur_idle     = 1'b0;
                n_cur_sleeping = 1'b0;
                n_state        = S_DONE;
            end
            S_TK_CMP: begin
                n_state = S_DONE;
                if (alu_flag) begin
                    if (r_ready_fill == CW'(MAX_THREADS)) begin
                        n_status = ST_FULL;
                    end else begin
                        rq_we        = 1'b1;
                        rq_wdata     = r_sq_rd_id;
                        n_ready_fill = r_ready_fill + CW'(1);
                        n_sleep_head = f_wrap(r_sleep_head, CW'(1));
                        n_sleep_fill = r_sleep_fill - CW'(1);
                        n_woken      = r_woken + CW'(1);
                        if (r_sleep_fill != CW'(1)) begin
                            sq_raddr = f_wrap(r_sleep_head, CW'(1));
                            n_state  = S_TK_CMP;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid    = 1'b1;
                    n_out_thread   = r_cur_idle ? '0 : r_cur_id;
                    n_out_idle     = r_cur_idle;
                    n_out_woken    = COUNT_W'(r_woken);
                    n_out_ready    = COUNT_W'(r_ready_fill);
                    n_out_sleeping = COUNT_W'(r_sleep_fill);
                    n_out_status   = r_status;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_ready_head   <= '0;
            r_ready_fill   <= '0;
            r_sleep_head   <= '0;
            r_sleep_fill   <= '0;
            r_cur_id       <= '0;
            r_cur_idle     <= 1'b0;
            r_cur_sleeping <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_ready_head   <= n_ready_head;
            r_ready_fill   <= n_ready_fill;
            r_sleep_head   <= n_sleep_head;
            r_sleep_fill   <= n_sleep_fill;
            r_cur_id       <= n_cur_id;
            r_cur_idle     <= n_cur_idle;
            r_cur_sleeping <= n_cur_sleeping;
            r_out_valid    <= n_out_valid;
        end
        r_action       <= n_action;
        r_tid          <= n_tid;
        r_tv           <= n_tv;
        r_now          <= n_now;
        r_key          <= n_key;
        r_k            <= n_k;
        r_woken        <= n_woken;
        r_status       <= n_status;
        r_out_thread   <= n_out_thread;
        r_out_idle     <= n_out_idle;
        r_out_woken    <= n_out_woken;
        r_out_ready    <= n_out_ready;
        r_out_sleeping <= n_out_sleeping;
        r_out_status   <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (rq_we) begin
            rq_mem[rq_waddr] <= rq_wdata;
        end
        r_rq_rd <= rq_mem[r_ready_head];
    end

    always_ff @(posedge i_clk) begin
        if (sq_we) begin
            sq_id[sq_waddr]   <= sq_wid;
            sq_time[sq_waddr] <= sq_wtime;
        end
        r_sq_rd_id   <= sq_id[sq_raddr];
        r_sq_rd_time <= sq_time[sq_raddr];
    end

    assign o_out_valid       = r_out_valid;
    assign o_running_thread  = r_out_thread;
    assign o_running_is_idle = r_out_idle;
    assign o_woken_count     = r_out_woken;
    assign o_ready_count     = r_out_ready;
    assign o_sleeping_count  = r_out_sleeping;
    assign o_status          = r_out_status;

    a_ready_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready_fill <= CW'(MAX_THREADS))
        else $error("ready queue over capacity");

    a_sleep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sleep_fill <= CW'(MAX_THREADS))
        else $error("sleep queue over capacity");

    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_idle |-> (r_cur_id == '0 && !r_cur_sleeping))
        else $error("idle thread state inconsistent");

    a_tick_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TK_CMP) |-> (r_sleep_fill != '0))
        else $error("tick compare on empty sleep queue");

    a_insert_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_CMP) |-> (r_k != '0 && r_k <= r_sleep_fill))
        else $error("insert position out of range");

    a_between_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_cur_sleeping)
        else $error("sleeping thread left running after an item");

endmodule

`default_nettype wire

// ===== verif/tb_fifo_scheduler_with_timed_sleep.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fifo_scheduler_with_timed_sleep
// Self-checking bench for the thread scheduler. A behavioral scheduler kept in
// step with the accepted beats predicts every result beat, and a monitor
// checks each result field against the oldest prediction. Directed cases come
// first, then queue-limit sequences, then long random traffic. Random gaps on
// the input side and random output stalls run in all but one random phase.
// ----------------------------------------------------------------------------
module tb_fifo_scheduler_with_timed_sleep;
    import fss_pkg::*;

    localparam int          DEPTH    = 16;
    localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [ID_W-1:0]     thread;
        logic                idle;
        logic [COUNT_W-1:0]  woken;
        logic [COUNT_W-1:0]  ready;
        logic [COUNT_W-1:0]  asleep;
        logic [STATUS_W-1:0] status;
    } sched_view_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [ACTION_W-1:0] i_action;
    logic [ID_W-1:0]     i_thread_id;
    logic [PORT_T_W-1:0] i_time_value;
    logic [PORT_T_W-1:0] i_now;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [ID_W-1:0]     o_running_thread;
    logic                o_running_is_idle;
    logic [COUNT_W-1:0]  o_woken_count;
    logic [COUNT_W-1:0]  o_ready_count;
    logic [COUNT_W-1:0]  o_sleeping_count;
    logic [STATUS_W-1:0] o_status;

    fifo_scheduler_with_timed_sleep uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_thread_id       (i_thread_id),
        .i_time_value      (i_time_value),
        .i_now             (i_now),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_running_thread  (o_running_thread),
        .o_running_is_idle (o_running_is_idle),
        .o_woken_count     (o_woken_count),
        .o_ready_count     (o_ready_count),
        .o_sleeping_count  (o_sleeping_count),
        .o_status          (o_status)
    );

    // predicted scheduler state
    logic [ID_W-1:0] rq_ids [DEPTH];
    int              rq_head;
    int              rq_fill;
    logic [ID_W-1:0] sl_ids [DEPTH];
    logic [63:0]     sl_wake [DEPTH];
    int              sl_fill;
    logic [ID_W-1:0] cur_id;
    bit              cur_idle;
    bit              cur_asleep;

    sched_view_t pending_views[$];
    sched_view_t got_view;
    sched_view_t want_view;
    int          fault_count;
    bit          no_idling;
    logic [63:0] wall_us;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idling || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void ready_append(logic [ID_W-1:0] id);
        rq_ids[(rq_head + rq_fill) % DEPTH] = id;
        rq_fill++;
    endfunction

    function automatic void switch_thread();
        logic [ID_W-1:0] next_id;
        if (rq_fill == 0) begin
            // a sleeping thread hands over to the idle thread
            if (cur_asleep) begin
                cur_idle   = 1'b1;
                cur_asleep = 1'b0;
                cur_id     = '0;
            end
            return;
        end
        next_id = rq_ids[rq_head];
        rq_head = (rq_head + 1) % DEPTH;
        rq_fill--;
        if (!cur_asleep && !cur_idle)
            ready_append(cur_id);
        cur_id     = next_id;
        cur_idle   = 1'b0;
        cur_asleep = 1'b0;
    endfunction

    function automatic t_status enter_sleep(logic [63:0] wake);
        int pos;
        if (cur_idle)
            return ST_IDLE_SLEEP;
        if (sl_fill >= DEPTH)
            return ST_FULL;
        // stable insert: behind every entry with an equal or earlier time
        pos = 0;
        while (pos < sl_fill && sl_wake[pos] <= wake)
            pos++;
        for (int k = sl_fill; k > pos; k--) begin
            sl_ids[k]  = sl_ids[k-1];
            sl_wake[k] = sl_wake[k-1];
        end
        sl_ids[pos]  = cur_id;
        sl_wake[pos] = wake;
        sl_fill++;
        cur_asleep = 1'b1;
        switch_thread();
        return ST_OK;
    endfunction

    function automatic sched_view_t advance_scheduler(t_action act, logic [ID_W-1:0] tid,
                                                      logic [63:0] tv, logic [63:0] now_us);
        sched_view_t v;
        t_status     st;
        int          woken;
        st    = ST_OK;
        woken = 0;
        case (act)
            ACT_CREATE: begin
                if (rq_fill >= DEPTH)
                    st = ST_FULL;
                else
                    ready_append(tid);
            end
            ACT_YIELD:       switch_thread();
            ACT_SLEEP_UNTIL: st = enter_sleep(tv);
            ACT_SLEEP_FOR:   st = enter_sleep((TIME_MAX - now_us < tv) ? TIME_MAX : now_us + tv);
            ACT_TICK: begin
                while (st == ST_OK && sl_fill > 0 && sl_wake[0] <= now_us) begin
                    if (rq_fill >= DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        ready_append(sl_ids[0]);
                        for (int k = 1; k < sl_fill; k++) begin
                            sl_ids[k-1]  = sl_ids[k];
                            sl_wake[k-1] = sl_wake[k];
                        end
                        sl_fill--;
                        woken++;
                    end
                end
            end
            default: ;
        endcase
        v.thread = cur_idle ? '0 : cur_id;
        v.idle   = cur_idle;
        v.woken  = COUNT_W'(woken);
        v.ready  = COUNT_W'(rq_fill);
        v.asleep = COUNT_W'(sl_fill);
        v.status = st;
        return v;
    endfunction

    // one input beat; the prediction is taken at the accepting edge
    task automatic issue_action(input t_action act, input logic [ID_W-1:0] tid,
                                input logic [63:0] tv, input logic [63:0] now_us);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_thread_id  <= tid;
        i_time_value <= tv;
        i_now        <= now_us;
        do @(posedge i_clk); while (o_in_stall);
        pending_views.push_back(advance_scheduler(act, tid, tv, now_us));
    endtask

    // output side back-pressure
    initial begin
        int n;
        i_out_stall <= 1'b0;
        forever begin
            n = pick_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_view = '{o_running_thread, o_running_is_idle, o_woken_count,
                         o_ready_count, o_sleeping_count, o_status};
            if (pending_views.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result beat: thr=%0d idle=%0b woken=%0d ready=%0d sleep=%0d st=%0d",
                             got_view.thread, got_view.idle, got_view.woken,
                             got_view.ready, got_view.asleep, got_view.status);
            end else begin
                want_view = pending_views.pop_front();
                if (got_view.thread !== want_view.thread || got_view.idle !== want_view.idle ||
                    got_view.woken !== want_view.woken || got_view.ready !== want_view.ready ||
                    got_view.asleep !== want_view.asleep || got_view.status !== want_view.status) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch at %0t: exp thr=%0d idle=%0b woken=%0d ready=%0d sleep=%0d st=%0d | got thr=%0d idle=%0b woken=%0d ready=%0d sleep=%0d st=%0d",
                                 $realtime,
                                 want_view.thread, want_view.idle, want_view.woken,
                                 want_view.ready, want_view.asleep, want_view.status,
                                 got_view.thread, got_view.idle, got_view.woken,
                                 got_view.ready, got_view.asleep, got_view.status);
                end
            end
        end
    end

    // boot thread, empty queues, field extremes, idle thread, saturation
    task automatic test_basic_actions();
        issue_action(ACT_YIELD, 4'h3, rand64(), rand64());
        issue_action(ACT_TICK, 4'h0, 64'h0, 64'h0);
        issue_action(ACT_CREATE, 4'hF, TIME_MAX, TIME_MAX);
        issue_action(ACT_CREATE, 4'h0, 64'h0, 64'h0);
        issue_action(ACT_CREATE, 4'hA, rand64(), rand64());
        issue_action(ACT_CREATE, 4'h5, rand64(), rand64());
        issue_action(ACT_YIELD, 4'h0, rand64(), rand64());
        issue_action(ACT_SLEEP_UNTIL, 4'h0, 64'h0, rand64());
        issue_action(ACT_SLEEP_FOR, 4'h0, TIME_MAX, 64'd5);
        issue_action(ACT_SLEEP_FOR, 4'h0, 64'd10, TIME_MAX - 64'd3);
        issue_action(ACT_SLEEP_UNTIL, 4'h0, TIME_MAX, 64'h0);
        // nothing left ready: the idle thread takes over
        issue_action(ACT_SLEEP_UNTIL, 4'h0, 64'h5555_5555_5555_5555, 64'h0);
        issue_action(ACT_SLEEP_UNTIL, 4'h0, 64'd1, 64'h0);
        issue_action(ACT_SLEEP_FOR, 4'h0, 64'd1, 64'h0);
        issue_action(ACT_YIELD, 4'h0, 64'h0, 64'h0);
        issue_action(ACT_TICK, 4'h0, rand64(), 64'h0);
        issue_action(ACT_YIELD, 4'h0, 64'h0, 64'h0);
        issue_action(ACT_TICK, 4'hF, 64'h0, 64'hAAAA_AAAA_AAAA_AAAA);
        issue_action(ACT_TICK, 4'h0, 64'h0, TIME_MAX);
        issue_action(ACT_YIELD, 4'h0, 64'h0, 64'h0);
    endtask

    // both queues filled to the brim, rejects, full-wake and partial-wake ticks
    task automatic test_queue_limits(input logic [63:0] base);
        while (rq_fill < DEPTH)
            issue_action(ACT_CREATE, 4'($urandom), rand64(), rand64());
        issue_action(ACT_CREATE, 4'($urandom), rand64(), rand64());
        while (sl_fill < DEPTH) begin
            if (cur_idle && rq_fill == 0)
                issue_action(ACT_CREATE, 4'($urandom), rand64(), rand64());
            else if (cur_idle)
                issue_action(ACT_YIELD, 4'($urandom), rand64(), rand64());
            else if ($urandom_range(0, 1))
                issue_action(ACT_SLEEP_UNTIL, 4'($urandom), base + $urandom_range(0, 3), rand64());
            else
                issue_action(ACT_SLEEP_FOR, 4'($urandom), 64'($urandom_range(0, 3)), base);
        end
        issue_action(ACT_CREATE, 4'($urandom), rand64(), rand64());
        if (cur_idle)
            issue_action(ACT_YIELD, 4'($urandom), rand64(), rand64());
        issue_action(ACT_SLEEP_UNTIL, 4'($urandom), rand64(), rand64());
        issue_action(ACT_SLEEP_FOR, 4'($urandom), rand64(), rand64());
        issue_action(ACT_TICK, 4'($urandom), rand64(), TIME_MAX);
        repeat (3) begin
            if (cur_idle && rq_fill == 0)
                issue_action(ACT_CREATE, 4'($urandom), rand64(), rand64());
            if (cur_idle)
                issue_action(ACT_YIELD, 4'($urandom), rand64(), rand64());
            issue_action(ACT_SLEEP_UNTIL, 4'($urandom), base, rand64());
        end
        while (rq_fill < DEPTH - 1)
            issue_action(ACT_CREATE, 4'($urandom), rand64(), rand64());
        issue_action(ACT_TICK, 4'($urandom), rand64(), TIME_MAX);
        issue_action(ACT_TICK, 4'($urandom), rand64(), TIME_MAX);
    endtask

    // mixed traffic around a running clock, with ties and wild times as noise
    task automatic test_random_traffic(input int n_items, input logic [63:0] base);
        int          pick;
        int          r;
        logic [63:0] tv;
        logic [63:0] now_us;
        wall_us = base;
        repeat (n_items) begin
            pick    = $urandom_range(0, 99);
            r       = $urandom_range(0, 9);
            wall_us = wall_us + $urandom_range(0, 20);
            if (pick < ((rq_fill >= DEPTH - 2) ? 6 : 22)) begin
                issue_action(ACT_CREATE, 4'($urandom), rand64(), rand64());
            end else if (pick < 38) begin
                issue_action(ACT_YIELD, 4'($urandom), rand64(), rand64());
            end else if (pick < 58) begin
                if (r == 0)
                    tv = rand64();
                else if (r == 1)
                    tv = wall_us - $urandom_range(0, 30);
                else
                    tv = wall_us + 8 * $urandom_range(0, 6);
                issue_action(ACT_SLEEP_UNTIL, 4'($urandom), tv, rand64());
            end else if (pick < 76) begin
                tv     = (r == 0) ? rand64() : 64'(8 * $urandom_range(0, 6));
                now_us = (r == 1) ? rand64() : wall_us;
                issue_action(ACT_SLEEP_FOR, 4'($urandom), tv, now_us);
            end else begin
                wall_us = wall_us + $urandom_range(0, 40);
                now_us  = (r == 0) ? rand64() : wall_us;
                issue_action(ACT_TICK, 4'($urandom), rand64(), now_us);
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_action     <= ACT_CREATE;
        i_thread_id  <= '0;
        i_time_value <= '0;
        i_now        <= '0;
        rq_head      = 0;
        rq_fill      = 0;
        sl_fill      = 0;
        cur_id       = '0;
        cur_idle     = 1'b0;
        cur_asleep   = 1'b0;
        fault_count  = 0;
        no_idling    = 1'b0;
        wall_us      = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_actions();
        test_queue_limits(64'd1000);
        test_queue_limits(TIME_MAX - 64'd2);
        test_random_traffic(500, 64'd0);
        no_idling = 1'b1;
        test_random_traffic(300, rand64());
        no_idling = 1'b0;
        test_random_traffic(500, TIME_MAX - 64'd4000);

        i_in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
design/fss_pkg.sv
design/fss_time_alu.sv
design/fifo_scheduler_with_timed_sleep.sv
verif/tb_fifo_scheduler_with_timed_sleep.sv
